@@ src/bam_pkg.sv @@
`default_nettype none
package bam_pkg;

  localparam int MAX_ARENA_LOG2_DEF = 12;
  localparam int MIN_BLOCK_LOG2_DEF = 4;

  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 12;
  localparam int GSIZE_W  = 13;
  localparam int REQ_W    = 16;
  localparam int LOG_W    = 6;
  localparam int CFG_W    = 4;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOMEM   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BADFREE = 2'd2;

  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic CFG_FIT_SEL    = 1'b0;
  localparam logic CFG_ARENA_LOG2 = 1'b1;

  localparam logic ACT_FREE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SPLIT,
    S_FREE_RD,
    S_FREE_EV,
    S_MERGE_RD,
    S_MERGE_EV,
    S_MERGE_HI,
    S_MERGE_LO,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

@@ src/bam_ram.sv @@
`default_nettype none
module bam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/buddy_allocator_fit_modes_core.sv @@
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  action, request_size, free_offset
// result    out        out_valid/out_stall status, block_offset, granted_size
// config    in         cfg_write          cfg_index, cfg_data
//
// Allocate: a table read per block head scanned (at most 2^(MAX_ARENA_LOG2 -
// MIN_BLOCK_LOG2) heads) and a write per split level. Free: frees the block, then
// per merge level a buddy read and two writes while the buddy is free; bad frees end
// early. Reset and a write of arena_log2 clear the per-slot valid bits at once, so the
// table reads as one free block spanning the arena with no clearing pass. in_stall is
// high while a transaction is in work; a stalled result holds in its register.
`default_nettype none
module buddy_allocator_fit_modes_core
  import bam_pkg::*;
#(
  parameter int MAX_ARENA_LOG2 = MAX_ARENA_LOG2_DEF,
  parameter int MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic                action,
  input  wire logic [REQ_W-1:0]    request_size,
  input  wire logic [REQ_W-1:0]    free_offset,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      logic [STATUS_W-1:0] status,
  output      logic [OFFSET_W-1:0] block_offset,
  output      logic [GSIZE_W-1:0]  granted_size,
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  localparam int SLOT_BITS = MAX_ARENA_LOG2 - MIN_BLOCK_LOG2;
  localparam int DEPTH     = 1 << SLOT_BITS;
  localparam int ORD_W     = $clog2(SLOT_BITS + 1);
  localparam int ENTRY_W   = ORD_W + 2;
  localparam int IDX_W     = SLOT_BITS + 1;
  localparam int LIM_W     = MAX_ARENA_LOG2 + 1;

  state_t state, state_next;

  logic [1:0]           fit_sel;
  logic [LOG_W-1:0]     arena_log2;
  logic [DEPTH-1:0]     vld;

  logic                 act;
  logic [REQ_W-1:0]     size_q;
  logic [REQ_W-1:0]     off_q;
  logic [LOG_W-1:0]     k_q;
  logic [ORD_W-1:0]     ro;
  logic [IDX_W-1:0]     idx;
  logic                 found;
  logic [SLOT_BITS-1:0] sel;
  logic [ORD_W-1:0]     so;
  logic [SLOT_BITS-1:0] s;
  logic [ORD_W-1:0]     o;
  logic [IDX_W-1:0]     b_q;
  logic [SLOT_BITS-1:0] rd_addr_q;
  logic                 rd_vld_q;
  logic [STATUS_W-1:0]  pend_status;
  logic [OFFSET_W-1:0]  pend_off;
  logic [GSIZE_W-1:0]   pend_size;

  logic                 ram_we;
  logic [SLOT_BITS-1:0] ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [SLOT_BITS-1:0] ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  bam_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Arena-wide quantities.
  logic [ORD_W-1:0] arena_ord;
  logic [IDX_W-1:0] nslots;
  assign arena_ord = ORD_W'(arena_log2 - LOG_W'(MIN_BLOCK_LOG2));
  assign nslots    = IDX_W'(1) << arena_ord;

  // A slot never written since the last clear reads as its reset value.
  logic [ENTRY_W-1:0] eff;
  logic               e_head, e_occ;
  logic [ORD_W-1:0]   e_ord;
  always_comb begin
    if (rd_vld_q) begin
      eff = ram_rdata;
    end else if (rd_addr_q == '0) begin
      eff = {1'b1, 1'b0, arena_ord};
    end else begin
      eff = '0;
    end
  end
  assign e_head = eff[ENTRY_W-1];
  assign e_occ  = eff[ENTRY_W-2];
  assign e_ord  = eff[ORD_W-1:0];

  // Request rounding: k = max(MIN_BLOCK_LOG2, ceil(log2(size))).
  logic [REQ_W-1:0] sm1;
  logic [LOG_W-1:0] clg, k_c;
  logic             too_big;
  always_comb begin
    sm1 = (size_q == '0) ? '0 : size_q - REQ_W'(1);
    clg = '0;
    for (int j = 0; j < REQ_W; j++) begin
      if (sm1[j]) clg = LOG_W'(j + 1);
    end
    k_c = (clg < LOG_W'(MIN_BLOCK_LOG2)) ? LOG_W'(MIN_BLOCK_LOG2) : clg;
  end
  assign too_big = k_c > arena_log2;

  logic [LIM_W-1:0] lim;
  logic             free_bad;
  assign lim      = LIM_W'(1) << arena_log2;
  assign free_bad = (LIM_W'(off_q) >= lim) || (off_q >= REQ_W'(lim))
                    || (off_q[MIN_BLOCK_LOG2-1:0] != '0);

  // Scan step.
  logic             fits, take, stop_first;
  logic [IDX_W-1:0] idx_adv;
  logic             scan_end;
  assign fits = e_head && !e_occ && (e_ord >= ro);
  assign take = fits && (!found || (fit_sel == FIT_BEST && e_ord < so)
                        || (fit_sel == FIT_WORST && e_ord > so));
  assign stop_first = fits && !found && fit_sel != FIT_BEST && fit_sel != FIT_WORST;
  assign idx_adv  = e_head ? idx + (IDX_W'(1) << e_ord) : idx + IDX_W'(1);
  assign scan_end = stop_first || (idx_adv >= nslots);

  // Merge step.
  logic [IDX_W-1:0]     b_c;
  logic                 buddy_ok;
  logic [SLOT_BITS-1:0] lo, hi;
  assign b_c      = {1'b0, s} ^ (IDX_W'(1) << o);
  assign buddy_ok = e_head && !e_occ && (e_ord == o);
  assign lo       = (s < b_q[SLOT_BITS-1:0]) ? s : b_q[SLOT_BITS-1:0];
  assign hi       = (s < b_q[SLOT_BITS-1:0]) ? b_q[SLOT_BITS-1:0] : s;

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_PREP;
      S_PREP: begin
        if (act == ACT_FREE) state_next = free_bad ? S_RESP : S_FREE_RD;
        else                 state_next = too_big ? S_RESP : S_SCAN_RD;
      end
      S_SCAN_RD:  state_next = S_SCAN_EV;
      S_SCAN_EV: begin
        if (scan_end) state_next = (found || fits) ? S_SPLIT : S_RESP;
        else          state_next = S_SCAN_RD;
      end
      S_SPLIT:    if (so <= ro) state_next = S_RESP;
      S_FREE_RD:  state_next = S_FREE_EV;
      S_FREE_EV:  state_next = (e_head && e_occ) ? S_MERGE_RD : S_RESP;
      S_MERGE_RD: state_next = (b_c >= nslots) ? S_RESP : S_MERGE_EV;
      S_MERGE_EV: state_next = buddy_ok ? S_MERGE_HI : S_RESP;
      S_MERGE_HI: state_next = S_MERGE_LO;
      S_MERGE_LO: state_next = S_MERGE_RD;
      S_RESP:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Table port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      S_SCAN_RD:  ram_raddr = idx[SLOT_BITS-1:0];
      S_FREE_RD:  ram_raddr = s;
      S_MERGE_RD: ram_raddr = b_c[SLOT_BITS-1:0];
      S_SPLIT: begin
        ram_we = 1'b1;
        if (so > ro) begin
          ram_waddr = sel + (SLOT_BITS'(1) << (so - ORD_W'(1)));
          ram_wdata = {1'b1, 1'b0, so - ORD_W'(1)};
        end else begin
          ram_waddr = sel;
          ram_wdata = {1'b1, 1'b1, ro};
        end
      end
      S_FREE_EV: begin
        ram_we    = e_head && e_occ;
        ram_waddr = s;
        ram_wdata = {1'b1, 1'b0, e_ord};
      end
      S_MERGE_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi;
        ram_wdata = '0;
      end
      S_MERGE_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo;
        ram_wdata = {1'b1, 1'b0, o + ORD_W'(1)};
      end
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fit_sel    <= '0;
      arena_log2 <= LOG_W'(MAX_ARENA_LOG2);
      vld        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write && cfg_index == CFG_FIT_SEL) begin
        fit_sel <= cfg_data[1:0];
      end
      if (cfg_write && cfg_index == CFG_ARENA_LOG2) begin
        if (LOG_W'(cfg_data) < LOG_W'(MIN_BLOCK_LOG2)) begin
          arena_log2 <= LOG_W'(MIN_BLOCK_LOG2);
        end else if (LOG_W'(cfg_data) > LOG_W'(MAX_ARENA_LOG2)) begin
          arena_log2 <= LOG_W'(MAX_ARENA_LOG2);
        end else begin
          arena_log2 <= LOG_W'(cfg_data);
        end
        vld <= '0;
      end else if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_addr_q <= ram_raddr;
    rd_vld_q  <= vld[ram_raddr];
    unique case (state)
      S_IDLE: begin
        act    <= action;
        size_q <= request_size;
        off_q  <= free_offset;
      end
      S_PREP: begin
        k_q   <= k_c;
        ro    <= ORD_W'(k_c - LOG_W'(MIN_BLOCK_LOG2));
        idx   <= '0;
        found <= 1'b0;
        s     <= SLOT_BITS'(off_q >> MIN_BLOCK_LOG2);
        pend_off  <= (act == ACT_FREE && !free_bad) ? off_q[OFFSET_W-1:0] : '0;
        pend_size <= '0;
        if (act == ACT_FREE) begin
          pend_status <= free_bad ? STAT_BADFREE : STAT_OK;
        end else begin
          pend_status <= too_big ? STAT_NOMEM : STAT_OK;
        end
      end
      S_SCAN_EV: begin
        if (take) begin
          found <= 1'b1;
          sel   <= idx[SLOT_BITS-1:0];
          so    <= e_ord;
        end
        idx <= idx_adv;
        if (scan_end && !(found || fits)) pend_status <= STAT_NOMEM;
      end
      S_SPLIT: begin
        if (so > ro) begin
          so <= so - ORD_W'(1);
        end else begin
          pend_off  <= OFFSET_W'({sel, {MIN_BLOCK_LOG2{1'b0}}});
          pend_size <= GSIZE_W'(1) << k_q;
        end
      end
      S_FREE_EV: begin
        o <= e_ord;
        if (!(e_head && e_occ)) begin
          pend_status <= STAT_BADFREE;
          pend_off    <= '0;
        end
      end
      S_MERGE_RD: b_q <= b_c;
      S_MERGE_LO: begin
        s <= lo;
        o <= o + ORD_W'(1);
      end
      S_RESP: begin
        if (out_free) begin
          status       <= pend_status;
          block_offset <= pend_off;
          granted_size <= pend_size;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ src/bam_checker.sv @@
`default_nettype none
module bam_checker
  import bam_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [OFFSET_W-1:0] block_offset,
  input wire logic [GSIZE_W-1:0]  granted_size
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(block_offset))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("engine took no time on a transaction");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_NOMEM || status == STAT_BADFREE)
      |-> block_offset == '0 && granted_size == '0)
    else $error("error result carries offset or size");

  a_size_pow2: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_OK |-> $onehot0(granted_size))
    else $error("granted size is not a power of two");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STAT_OK || status == STAT_NOMEM || status == STAT_BADFREE)
    else $error("unknown status code");

endmodule

bind buddy_allocator_fit_modes_core bam_checker u_bam_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .block_offset (block_offset),
  .granted_size (granted_size)
);
`default_nettype wire
